FILE: rtl/hrgb_pkg.sv
// Shared types and constants for the hex RGB color spec parser.
package hrgb_pkg;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NO_HASH    = 2'd1,
        STATUS_BAD_LENGTH = 2'd2,
        STATUS_BAD_DIGIT  = 2'd3
    } status_t;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned ACCUM_W = 48;
    localparam int unsigned COLOR_W = 16;

    localparam logic [CHAR_W-1:0] CHAR_HASH    = 8'h23;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;
    // 'A' - 10 and 'a' - 10
    localparam logic [CHAR_W-1:0] UPPER_BASE   = 8'h37;
    localparam logic [CHAR_W-1:0] LOWER_BASE   = 8'h57;

    localparam logic [COUNT_W-1:0] MAX_DIGITS  = 4'd12;
    localparam logic [COUNT_W-1:0] COUNT_SAT   = 4'd13;
    localparam logic [COUNT_W-1:0] LEN_THREE   = 4'd3;
    localparam logic [COUNT_W-1:0] LEN_SIX     = 4'd6;
    localparam logic [COUNT_W-1:0] LEN_NINE    = 4'd9;
    localparam logic [COUNT_W-1:0] LEN_TWELVE  = 4'd12;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    typedef struct packed {
        logic               hash_seen;
        logic [COUNT_W-1:0] count;
        logic [ACCUM_W-1:0] accum;
        logic               bad_digit;
    } parse_state_t;

    typedef struct packed {
        status_t            status;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } color_result_t;

endpackage

FILE: rtl/hrgb_hex_decode.sv
// ASCII hex digit decoder: digit value and a flag for valid hex characters.
module hrgb_hex_decode (
    input  logic [7:0]             char_code,
    output hrgb_pkg::hex_digit_t   digit
);
    import hrgb_pkg::*;

    logic [CHAR_W-1:0] upper_diff;
    logic [CHAR_W-1:0] lower_diff;

    assign upper_diff = char_code - UPPER_BASE;
    assign lower_diff = char_code - LOWER_BASE;

    always_comb
    begin
        digit.is_hex = 1'b0;
        digit.value  = 4'd0;
        priority if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE)
        begin
            digit.is_hex = 1'b1;
            digit.value  = char_code[3:0];
        end
        else if (char_code >= CHAR_UPPER_A && char_code <= CHAR_UPPER_F)
        begin
            digit.is_hex = 1'b1;
            digit.value  = upper_diff[3:0];
        end
        else if (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_F)
        begin
            digit.is_hex = 1'b1;
            digit.value  = lower_diff[3:0];
        end
        else
        begin
            digit.is_hex = 1'b0;
            digit.value  = 4'd0;
        end
    end

endmodule

FILE: rtl/hrgb_result_format.sv
// Status check and red/green/blue split of the accumulated digits.
module hrgb_result_format (
    input  hrgb_pkg::parse_state_t  state_in,
    output hrgb_pkg::color_result_t result
);
    import hrgb_pkg::*;

    logic               length_ok;
    logic [ACCUM_W-1:0] acc;

    assign acc       = state_in.accum;
    assign length_ok = (state_in.count == LEN_THREE) || (state_in.count == LEN_SIX) ||
                       (state_in.count == LEN_NINE)  || (state_in.count == LEN_TWELVE);

    always_comb
    begin
        result.status = STATUS_OK;
        result.red    = '0;
        result.green  = '0;
        result.blue   = '0;
        priority if (!state_in.hash_seen)
        begin
            result.status = STATUS_NO_HASH;
        end
        else if (!length_ok)
        begin
            result.status = STATUS_BAD_LENGTH;
        end
        else if (state_in.bad_digit)
        begin
            result.status = STATUS_BAD_DIGIT;
        end
        else
        begin
            result.status = STATUS_OK;
            // left-align each part, low bits stay zero
            unique case (state_in.count)
                LEN_THREE:
                begin
                    result.red   = {acc[11:8], 12'd0};
                    result.green = {acc[7:4],  12'd0};
                    result.blue  = {acc[3:0],  12'd0};
                end
                LEN_SIX:
                begin
                    result.red   = {acc[23:16], 8'd0};
                    result.green = {acc[15:8],  8'd0};
                    result.blue  = {acc[7:0],   8'd0};
                end
                LEN_NINE:
                begin
                    result.red   = {acc[35:24], 4'd0};
                    result.green = {acc[23:12], 4'd0};
                    result.blue  = {acc[11:0],  4'd0};
                end
                default:
                begin
                    result.red   = acc[47:32];
                    result.green = acc[31:16];
                    result.blue  = acc[15:0];
                end
            endcase
        end
    end

endmodule

FILE: rtl/hex_rgb_color_spec_parser_unit.sv
// Hex RGB color spec parser: character stream in, one color result per spec out.
//
// Input channel: one ASCII character per transfer (char_code), with last_char
// set on the final character of a spec. A spec is '#' and 3, 6, 9 or 12 hex
// digits. Output channel: one result per spec (status, red, green, blue),
// sent after the transfer that carried last_char; other characters give none.
// Each character is taken into an input register, then decoded and folded into
// the parse state as it leaves that register; a final character waits there
// while the output register holds a result under out_stall. The result of a
// final character is written to the output register in the same cycle in which
// it leaves the input register, and out_valid is registered from that write.
// Throughput: one character per cycle while no final character is held back.
// in_stall rises only when a final character sits in the input register while
// the output register holds a result under out_stall; other characters are
// absorbed even while the output is stalled.
// Reset clears both valid flags and returns the parser to the start of a spec.
module hex_rgb_color_spec_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] red,
    output logic [15:0] green,
    output logic [15:0] blue
);
    import hrgb_pkg::*;

    // input register
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [CHAR_W-1:0]  s1_char_reg;
    logic               s1_last_reg;

    // parse state
    logic               at_first_reg;
    logic               at_first_next;
    logic               hash_seen_reg;
    logic               hash_seen_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [ACCUM_W-1:0] accum_reg;
    logic [ACCUM_W-1:0] accum_next;
    logic               bad_reg;
    logic               bad_next;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    color_result_t      result_reg;

    logic               in_fire;
    logic               out_free;
    logic               s1_fire;
    logic               s1_done;
    hex_digit_t         digit;
    parse_state_t       snap;
    color_result_t      result;

    hrgb_hex_decode u_decode (
        .char_code (s1_char_reg),
        .digit     (digit)
    );

    assign out_free = !out_valid_reg || !out_stall;
    // a non-final character never waits on the output side
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign s1_done  = s1_fire && s1_last_reg;
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        at_first_next  = at_first_reg;
        hash_seen_next = hash_seen_reg;
        count_next     = count_reg;
        accum_next     = accum_reg;
        bad_next       = bad_reg;
        priority if (at_first_reg)
        begin
            at_first_next  = 1'b0;
            hash_seen_next = (s1_char_reg == CHAR_HASH);
        end
        else if (hash_seen_reg)
        begin
            bad_next = bad_reg || !digit.is_hex;
            if (count_reg < MAX_DIGITS)
            begin
                accum_next = {accum_reg[ACCUM_W-5:0], digit.value};
            end
            if (count_reg < COUNT_SAT)
            begin
                count_next = count_reg + 4'd1;
            end
        end
        else
        begin
            // no hash: drop the rest of the spec
            bad_next = bad_reg;
        end
    end

    assign snap.hash_seen = hash_seen_next;
    assign snap.count     = count_next;
    assign snap.accum     = accum_next;
    assign snap.bad_digit = bad_next;

    hrgb_result_format u_format (
        .state_in (snap),
        .result   (result)
    );

    always_comb
    begin
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_comb
    begin
        if (s1_done)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            at_first_reg  <= 1'b1;
            hash_seen_reg <= 1'b0;
            count_reg     <= '0;
            accum_reg     <= '0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                if (s1_last_reg)
                begin
                    // spec complete: back to the start
                    at_first_reg  <= 1'b1;
                    hash_seen_reg <= 1'b0;
                    count_reg     <= '0;
                    accum_reg     <= '0;
                    bad_reg       <= 1'b0;
                end
                else
                begin
                    at_first_reg  <= at_first_next;
                    hash_seen_reg <= hash_seen_next;
                    count_reg     <= count_next;
                    accum_reg     <= accum_next;
                    bad_reg       <= bad_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_char_reg <= char_code;
            s1_last_reg <= last_char;
        end
        if (s1_done)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = result_reg.status;
    assign red       = result_reg.red;
    assign green     = result_reg.green;
    assign blue      = result_reg.blue;

`ifndef SYNTHESIS
    a_stall_only_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_last_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked final character");

    a_colors_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_OK) |-> (red == '0 && green == '0 && blue == '0))
        else $error("non-ok result carries color data");

    a_restart_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        s1_done |=> (at_first_reg && !hash_seen_reg && count_reg == '0 && !bad_reg))
        else $error("parse state not cleared after final character");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_SAT)
        else $error("digit count beyond saturation");

    a_result_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_done |=> out_valid_reg)
        else $error("final character did not produce a result");
`endif

endmodule

FILE: tb/hex_rgb_color_spec_parser_unit_tb.sv
// Self-checking testbench for the hex RGB color spec parser: directed specs, then random specs.
`timescale 1ns / 100ps

module hex_rgb_color_spec_parser_unit_tb;
    import hrgb_pkg::*;

    typedef logic [8*13-1:0] spec_text_t;

    // One directed spec; text is right-aligned, first character in the top used byte
    typedef struct {
        int unsigned   len;
        spec_text_t    text;
        bit            fixed;
        color_result_t color;
    } spec_row_t;

    // Answer that goes with each final character, in transfer order
    typedef struct {
        bit            fixed;
        color_result_t color;
    } answer_t;

    localparam int unsigned RANDOM_CHARS = 850;
    localparam int unsigned IDLE_PCT     = 9;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  char_code = 8'h00;
    logic        last_char = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;

    // Parse state of the predictor
    logic               spec_start  = 1'b1;
    logic               spec_hashed = 1'b0;
    logic [COUNT_W-1:0] spec_count  = '0;
    logic [ACCUM_W-1:0] spec_digits = '0;
    logic               spec_bad    = 1'b0;

    color_result_t colors_due[$];
    answer_t       listed_answers[$];
    color_result_t want;

    spec_row_t   spec_table [7];
    bit          quiet        = 1'b0;
    int unsigned chars_sent   = 0;
    int unsigned specs_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned errors       = 0;
    int unsigned status_count [4] = '{0, 0, 0, 0};

    hex_rgb_color_spec_parser_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Fold one accepted character into the parse state; on the final one queue the color
    task automatic absorb_char(input logic [7:0] c, input logic fin);
        logic [4:0]         nib;
        int unsigned        width;
        logic [ACCUM_W-1:0] mask;
        color_result_t      res;
        answer_t            listed;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            nib = 5'(c - CHAR_ZERO);
        else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
            nib = 5'(c - UPPER_BASE);
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
            nib = 5'(c - LOWER_BASE);
        else
            nib = 5'd16;

        if (spec_start)
        begin
            spec_start  = 1'b0;
            spec_hashed = (c == CHAR_HASH);
        end
        else if (spec_hashed)
        begin
            if (nib[4])
                spec_bad = 1'b1;
            // digits past the twelfth are not kept; the count saturates at 13
            if (spec_count < MAX_DIGITS)
                spec_digits = {spec_digits[ACCUM_W-5:0], nib[3:0]};
            if (spec_count < COUNT_SAT)
                spec_count = spec_count + 1'b1;
        end

        if (fin)
        begin
            res = '{STATUS_OK, 16'h0000, 16'h0000, 16'h0000};
            if (!spec_hashed)
                res.status = STATUS_NO_HASH;
            else if (spec_count != LEN_THREE && spec_count != LEN_SIX &&
                     spec_count != LEN_NINE && spec_count != LEN_TWELVE)
                res.status = STATUS_BAD_LENGTH;
            else if (spec_bad)
                res.status = STATUS_BAD_DIGIT;
            else
            begin
                width     = (int'(spec_count) / 3) * 4;
                mask      = (48'd1 << width) - 48'd1;
                res.blue  = 16'((spec_digits & mask) << (COLOR_W - width));
                res.green = 16'(((spec_digits >> width) & mask) << (COLOR_W - width));
                res.red   = 16'(((spec_digits >> (2 * width)) & mask) << (COLOR_W - width));
            end

            if (listed_answers.size() != 0)
            begin
                listed = listed_answers.pop_front();
                if (listed.fixed)
                    res = listed.color;
            end
            colors_due.push_back(res);
            status_count[res.status]++;

            spec_start  = 1'b1;
            spec_hashed = 1'b0;
            spec_count  = '0;
            spec_digits = '0;
            spec_bad    = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            absorb_char(char_code, last_char);
    end

    always @(posedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (colors_due.size() == 0)
            begin
                $error("result with nothing outstanding: status %0d red %h green %h blue %h",
                       status, red, green, blue);
                errors++;
            end
            else
            begin
                want = colors_due.pop_front();
                if (status !== 2'(want.status))
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    errors++;
                end
                if (red !== want.red)
                begin
                    $error("red: expected %h, got %h", want.red, red);
                    errors++;
                end
                if (green !== want.green)
                begin
                    $error("green: expected %h, got %h", want.green, green);
                    errors++;
                end
                if (blue !== want.blue)
                begin
                    $error("blue: expected %h, got %h", want.blue, blue);
                    errors++;
                end
            end
        end
    end

    function automatic logic [7:0] hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(15));
        if (v < 4'd10)
            return CHAR_ZERO + 8'(v);
        else if ($urandom_range(1) == 0)
            return CHAR_UPPER_A + 8'(v - 4'd10);
        else
            return CHAR_LOWER_A + 8'(v - 4'd10);
    endfunction

    // Hold the character until its transfer completes
    task automatic send_char(input logic [7:0] c, input logic fin);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        last_char <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_spec(input logic [7:0] text[$], input bit fixed,
                             input color_result_t color);
        answer_t entry;
        entry.fixed = fixed;
        entry.color = color;
        listed_answers.push_back(entry);
        specs_sent++;
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], i == text.size() - 1);
    endtask

    task automatic random_spec();
        logic [7:0]    text[$];
        int unsigned   kind;
        int unsigned   n;
        color_result_t blank;
        blank = '{STATUS_OK, 16'h0000, 16'h0000, 16'h0000};
        kind  = $urandom_range(99);
        if (kind < 70)
        begin
            n = 3 * $urandom_range(4, 1);
            text.push_back(CHAR_HASH);
            repeat (n) text.push_back(hex_char());
        end
        else if (kind < 85)
        begin
            // any length up to past saturation, some bytes arbitrary
            n = $urandom_range(15);
            text.push_back(CHAR_HASH);
            repeat (n)
                text.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : hex_char());
        end
        else if (kind < 93)
        begin
            // valid length with one arbitrary byte
            n = 3 * $urandom_range(4, 1);
            text.push_back(CHAR_HASH);
            repeat (n) text.push_back(hex_char());
            text[$urandom_range(n, 1)] = 8'($urandom_range(255));
        end
        else
        begin
            n = $urandom_range(6, 1);
            repeat (n) text.push_back(8'($urandom_range(255)));
        end
        send_spec(text, 1'b0, blank);
    endtask

    initial
    begin
        logic [7:0]  text[$];
        int unsigned base;
        bit          paused;

        spec_table = '{
            '{4,  spec_text_t'("#fFf"),  1'b1, '{STATUS_OK, 16'hF000, 16'hF000, 16'hF000}},
            '{1,  spec_text_t'("#"),     1'b1, '{STATUS_BAD_LENGTH, 16'h0, 16'h0, 16'h0}},
            '{4,  spec_text_t'({8'hFF, "#12"}),
                                         1'b1, '{STATUS_NO_HASH, 16'h0, 16'h0, 16'h0}},
            '{4,  spec_text_t'("#1g3"),  1'b1, '{STATUS_BAD_DIGIT, 16'h0, 16'h0, 16'h0}},
            '{4,  spec_text_t'({"#", 8'h00, "12"}),
                                         1'b1, '{STATUS_BAD_DIGIT, 16'h0, 16'h0, 16'h0}},
            '{7,  spec_text_t'("#09afAF"),
                                         1'b0, '{STATUS_OK, 16'h0, 16'h0, 16'h0}},
            '{13, spec_text_t'("#0123456789Ab"),
                                         1'b1, '{STATUS_OK, 16'h0123, 16'h4567, 16'h89AB}}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (spec_table[r])
        begin
            text.delete();
            for (int i = 0; i < spec_table[r].len; i++)
                text.push_back(spec_table[r].text[8 * (spec_table[r].len - 1 - i) +: 8]);
            send_spec(text, spec_table[r].fixed, spec_table[r].color);
        end

        // drain before the random part
        in_valid <= 1'b0;
        while (results_seen != specs_sent)
            @(posedge clk);

        base   = chars_sent;
        paused = 1'b0;
        while (chars_sent - base < RANDOM_CHARS)
        begin
            quiet = (chars_sent - base >= 250) && (chars_sent - base < 450);
            if (!paused && chars_sent - base >= 500)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                while (results_seen != specs_sent)
                    @(posedge clk);
            end
            random_spec();
        end
        quiet = 1'b0;

        in_valid <= 1'b0;
        while (results_seen != specs_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (colors_due.size() != 0)
        begin
            $error("%0d expected results never arrived", colors_due.size());
            errors++;
        end

        $display("Sent %0d characters in %0d specs with random gaps, output stalls and drain pauses.",
                 chars_sent, specs_sent);
        $display("Results: ok %0d, no hash %0d, bad length %0d, bad digit %0d; %0d mismatches.",
                 status_count[STATUS_OK], status_count[STATUS_NO_HASH],
                 status_count[STATUS_BAD_LENGTH], status_count[STATUS_BAD_DIGIT], errors);
        if (errors == 0)
            $display("** hex_rgb_color_spec_parser_unit: PASSED **");
        else
            $display("** hex_rgb_color_spec_parser_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout: %0d of %0d results received.", results_seen, specs_sent);
        $display("** hex_rgb_color_spec_parser_unit: FAILED **");
        $finish;
    end

endmodule
